// ===== src/psr_pkg.sv =====
package psr_pkg;

  // Ring depth and derived widths
  localparam int unsigned MAX_PERIOD = 1024;
  localparam int unsigned PTR_W      = $clog2(MAX_PERIOD);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Field widths
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned GAIN_W   = 15;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned OUT_W    = 8;

  // Configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_PERIOD = 1'b0,
    REG_GAIN   = 1'b1
  } psr_reg_t;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(18);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(32637);
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(2);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(MAX_PERIOD);

  typedef logic        [PTR_W-1:0]    ptr_t;
  typedef logic        [CNT_W-1:0]    cnt_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Q1.15 sample times 127, truncated toward zero
  function automatic logic signed [OUT_W-1:0] to_int8(input sample_t v);
    logic signed [SAMPLE_W+7:0] prod;
    logic signed [SAMPLE_W+7:0] biased;
    logic signed [SAMPLE_W+7:0] shifted;
    prod    = ($signed({v, 7'b0}) - (SAMPLE_W+8)'(v));
    biased  = prod[SAMPLE_W+7] ? prod + (SAMPLE_W+8)'(32767) : prod;
    shifted = biased >>> 15;
    return shifted[OUT_W-1:0];
  endfunction

endpackage

// ===== src/psr_ring.sv =====
module psr_ring
  import psr_pkg::*;
(
  input  logic    clk,
  input  logic    wr_en,
  input  ptr_t    wr_addr,
  input  sample_t wr_data,
  input  ptr_t    rd_addr,
  output sample_t rd_data
);

  sample_t mem [MAX_PERIOD];

  // Write one entry per cycle while wr_en is high
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/plucked_string_synth.sv =====
// Channel  Direction  Word                          Handshake
// in_      input      in_pluck, in_noise_sample     in_valid / in_ready
// out_     output     out_sample_out, out_exciting  out_valid / out_ready
// cfg_     apb slave  period_length @0, decay_gain @4  psel/penable, pready=1
//
// One word per cycle sustained while out_ready stays high; a word passes
// through the input register and then the result register. The ring read for
// the next word is issued in the cycle before it, from the next position state,
// with a forward path for the entry written that same cycle. Reset (rst_n low,
// synchronous) clears position, excitation count and held sample, and loads the
// register defaults; the ring itself is not cleared. A stall on out_ready holds
// the result and the input stage, and input is taken again as soon as the result register frees.
module plucked_string_synth
  import psr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_pluck,
  input  logic signed [SAMPLE_W-1:0] in_noise_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_sample_out,
  output logic                    out_exciting,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [ADDR_W-1:0]       cfg_paddr,
  input  logic [DATA_W-1:0]       cfg_pwdata,
  output logic [DATA_W-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  // Configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [GAIN_W-1:0]   gain_r;
  psr_reg_t            cfg_reg;
  logic                cfg_wr;

  // Input stage
  logic    s1_valid_r;
  logic    s1_pluck_r;
  sample_t s1_noise_r;
  logic    byp_r;
  sample_t byp_data_r;

  // Voice state
  ptr_t    ring_pos_r, ring_pos_nxt;
  cnt_t    excite_r, excite_nxt;
  sample_t held_r, held_nxt;

  // Result stage
  logic    out_valid_r;
  sample_t out_value_r;
  logic    out_exc_r;

  // Compute signals
  logic [PERIOD_W-1:0]  p_eff;
  logic                 advance;
  ptr_t                 pos;
  cnt_t                 exc_cnt;
  logic [CNT_W-1:0]     pos_inc;
  ptr_t                 nxt;
  logic                 exc;
  sample_t              ring_q;
  sample_t              next_smp;
  logic signed [SAMPLE_W:0]    sum;
  logic signed [SAMPLE_W+16:0] prod;
  sample_t              value;
  ptr_t                 ra_pos;
  logic [CNT_W-1:0]     ra_inc;
  ptr_t                 rd_addr;

  // APB access
  assign cfg_pready = 1'b1;
  assign cfg_reg    = psr_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_PERIOD: period_r <= cfg_pwdata[PERIOD_W-1:0];
        REG_GAIN:   gain_r   <= cfg_pwdata[GAIN_W-1:0];
        default:    period_r <= period_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_PERIOD: cfg_prdata = DATA_W'(period_r);
      REG_GAIN:   cfg_prdata = DATA_W'(gain_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Clamp the period into the ring
  always_comb begin
    priority if (period_r < PERIOD_MIN) begin
      p_eff = PERIOD_MIN;
    end else if (period_r > PERIOD_MAX) begin
      p_eff = PERIOD_MAX;
    end else begin
      p_eff = period_r;
    end
  end

  // Handshake: the input stage moves on when the result register frees
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // Position, excitation and filter step for the word in the input stage
  always_comb begin
    pos     = '0;
    exc_cnt = '0;
    if (!s1_pluck_r) begin
      exc_cnt = excite_r;
      if (PERIOD_W'(ring_pos_r) < p_eff) begin
        pos = ring_pos_r;
      end
    end
    pos_inc = CNT_W'(pos) + CNT_W'(1);
    nxt     = (PERIOD_W'(pos_inc) >= p_eff) ? '0 : pos_inc[PTR_W-1:0];
    exc     = PERIOD_W'(exc_cnt) < p_eff;

    next_smp = byp_r ? byp_data_r : ring_q;
    sum      = (SAMPLE_W+1)'(held_r) + (SAMPLE_W+1)'(next_smp);
    prod     = sum * $signed({1'b0, gain_r});
    value    = exc ? s1_noise_r : prod[SAMPLE_W+15:16];
  end

  // Next state of the voice
  always_comb begin
    ring_pos_nxt = ring_pos_r;
    excite_nxt   = excite_r;
    held_nxt     = held_r;
    if (advance) begin
      ring_pos_nxt = nxt;
      if (exc) begin
        excite_nxt = exc_cnt + CNT_W'(1);
        if (pos == '0) begin
          held_nxt = s1_noise_r;
        end
      end else begin
        held_nxt = next_smp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_pos_r <= '0;
      excite_r   <= '0;
      held_r     <= '0;
    end else begin
      ring_pos_r <= ring_pos_nxt;
      excite_r   <= excite_nxt;
      held_r     <= held_nxt;
    end
  end

  // Look-ahead read address: the entry after the next word's position
  always_comb begin
    ra_pos  = (PERIOD_W'(ring_pos_nxt) < p_eff) ? ring_pos_nxt : '0;
    ra_inc  = CNT_W'(ra_pos) + CNT_W'(1);
    rd_addr = (PERIOD_W'(ra_inc) >= p_eff) ? '0 : ra_inc[PTR_W-1:0];
  end

  psr_ring u_ring (
    .clk     (clk),
    .wr_en   (advance),
    .wr_addr (pos),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (ring_q)
  );

  // Forward the word written in the same cycle as the read
  always_ff @(posedge clk) begin
    byp_r      <= advance && (rd_addr == pos);
    byp_data_r <= value;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pluck_r <= in_pluck;
      s1_noise_r <= in_noise_sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value_r <= value;
      out_exc_r   <= exc;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = to_int8(out_value_r);
  assign out_exciting   = out_exc_r;

endmodule
